// File: hdl/vertex_attribute_splitter_core_defines.svh
// Assertion macros shared by the design files.
`ifndef VERTEX_ATTRIBUTE_SPLITTER_CORE_DEFINES_SVH
`define VERTEX_ATTRIBUTE_SPLITTER_CORE_DEFINES_SVH
// Checks that a condition implies a consequence at the same edge.
`define VAS_ASSERT_IMPLY(label, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error(msg);
// Checks with a non-overlapping implication (|=>) that a condition implies a consequence.
`define VAS_ASSERT_NEXT(label, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error(msg);
`endif

// File: hdl/vas_pkg.sv
package vas_pkg;
	localparam int OrigVertices = 4096;
	localparam int TableEntries = 16384;
	localparam int ExportVertices = 8192;
	localparam int EW = $clog2(TableEntries);
	localparam int XW = $clog2(ExportVertices);
	localparam int OW = 12;
	localparam int QDEPTH = 2;

	localparam logic [1:0] REG_SPLIT_NORMAL = 2'd0;
	localparam logic [1:0] REG_SPLIT_TEXCOORD = 2'd1;
	localparam logic [1:0] REG_SPLIT_COLOR = 2'd2;

	typedef enum logic [1:0] {
		FUNC_ADD = 2'd0,
		FUNC_READ = 2'd1,
		FUNC_CLEAR = 2'd2,
		FUNC_NONE = 2'd3
	} func_t;

	typedef struct packed {
		func_t func;
		logic [OW-1:0] orig;
		logic [15:0] nx;
		logic [15:0] ny;
		logic [15:0] nz;
		logic [31:0] tc;
		logic [31:0] col;
		logic [12:0] ridx;
	} cmd_t;

	typedef struct packed {
		logic [12:0] export_vertex;
		logic is_new;
		logic table_full;
		logic [11:0] orig;
		logic [31:0] sx;
		logic [31:0] sy;
		logic [31:0] sz;
		logic [15:0] tu;
		logic [15:0] tv;
		logic [31:0] col;
	} res_t;

	function automatic logic [31:0] sat_add(input logic [31:0] s, input logic [15:0] a);
		logic [32:0] r;
		r = {s[31], s} + {{17{a[15]}}, a};
		if (r[32] != r[31]) begin
			sat_add = r[32] ? 32'h8000_0000 : 32'h7fff_ffff;
		end else begin
			sat_add = r[31:0];
		end
	endfunction
endpackage

// File: hdl/vas_ram.sv
module vas_ram #(
	parameter int Width = 8,
	parameter int Depth = 4
) (
	input logic clk,
	input logic we,
	input logic [$clog2(Depth)-1:0] waddr,
	input logic [Width-1:0] wdata,
	input logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: hdl/vas_front.sv
module vas_front import vas_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic [1:0] func,
	input logic [11:0] orig_vertex,
	input logic signed [15:0] normal_x,
	input logic signed [15:0] normal_y,
	input logic signed [15:0] normal_z,
	input logic signed [15:0] tex_u,
	input logic signed [15:0] tex_v,
	input logic [31:0] corner_color,
	input logic [12:0] read_index,
	output logic cq_valid,
	output cmd_t cq_data,
	input logic cq_take
);
	`include "vertex_attribute_splitter_core_defines.svh"

	cmd_t q_q [QDEPTH];
	logic rd_q;
	logic wr_q;
	logic [1:0] cnt_q;
	logic acc;
	cmd_t cin;

	assign full = (cnt_q == 2'(QDEPTH));
	assign acc = push && !full && (func != FUNC_NONE);
	assign cq_valid = (cnt_q != 2'd0);
	assign cq_data = q_q[rd_q];

	always_comb begin
		cin.func = func_t'(func);
		cin.orig = orig_vertex;
		cin.nx = normal_x;
		cin.ny = normal_y;
		cin.nz = normal_z;
		cin.tc = {tex_v, tex_u};
		cin.col = corner_color;
		cin.ridx = read_index;
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			q_q[wr_q] <= cin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (acc) begin
				wr_q <= ~wr_q;
			end
			if (cq_take) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + 2'(acc) - 2'(cq_take);
		end
	end

	`VAS_ASSERT_IMPLY(a_take_valid, cq_take, cq_valid, "queue popped while empty")
	`VAS_ASSERT_IMPLY(a_cnt_range, 1'b1, cnt_q <= 2'(QDEPTH), "queue count out of range")
	`VAS_ASSERT_NEXT(a_cnt_up, acc && !cq_take, cnt_q == $past(cnt_q) + 2'd1,
		"queue count missed a push")
endmodule

// File: hdl/vas_back.sv
module vas_back import vas_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_n,
	input logic cfg_t,
	input logic cfg_c,
	input logic cq_valid,
	input cmd_t cq_data,
	output logic cq_take,
	output logic empty,
	input logic pop,
	output res_t res
);
	`include "vertex_attribute_splitter_core_defines.svh"

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_WALK = 8'b0000_0010,
		S_CMP = 8'b0000_0100,
		S_NXT = 8'b0000_1000,
		S_RD1 = 8'b0001_0000,
		S_RD2 = 8'b0010_0000,
		S_RD3 = 8'b0100_0000,
		S_CLR = 8'b1000_0000
	} state_t;

	state_t st_q;
	cmd_t c_q;
	logic [EW-1:0] e_q;
	logic [EW:0] steps_q;
	logic [XW:0] cnt_q;
	logic [EW:0] ofree_q;
	logic [EW-1:0] clr_q;
	logic out_v_q;
	res_t out_q;

	// Valid and link store in one memory: {valid, next}.
	logic lk_we;
	logic [EW-1:0] lk_wa, lk_ra;
	logic [EW:0] lk_wd, lk_rd;
	logic dt_we;
	logic [EW-1:0] dt_wa, dt_ra;
	logic [XW+159:0] dt_wd, dt_rd;
	logic xp_we;
	logic [XW-1:0] xp_wa, xp_ra;
	logic [EW+11:0] xp_wd, xp_rd;

	vas_ram #(.Width(EW+1), .Depth(TableEntries)) u_lk (
		.clk(clk), .we(lk_we), .waddr(lk_wa), .wdata(lk_wd), .raddr(lk_ra), .rdata(lk_rd));
	vas_ram #(.Width(XW+160), .Depth(TableEntries)) u_dt (
		.clk(clk), .we(dt_we), .waddr(dt_wa), .wdata(dt_wd), .raddr(dt_ra), .rdata(dt_rd));
	vas_ram #(.Width(EW+12), .Depth(ExportVertices)) u_xp (
		.clk(clk), .we(xp_we), .waddr(xp_wa), .wdata(xp_wd), .raddr(xp_ra), .rdata(xp_rd));

	logic [31:0] snx, sny, snz;
	logic dif, lvalid, has_next, xfull, ofull, busy_out;
	logic [EW-1:0] lnext;
	logic [XW-1:0] eidx;
	logic [31:0] d_sx, d_sy, d_sz, d_tc, d_col;

	assign snx = {{16{c_q.nx[15]}}, c_q.nx};
	assign sny = {{16{c_q.ny[15]}}, c_q.ny};
	assign snz = {{16{c_q.nz[15]}}, c_q.nz};
	assign lvalid = lk_rd[EW];
	assign lnext = lk_rd[EW-1:0];
	assign has_next = (lnext != {EW{1'b1}});
	assign {eidx, d_sx, d_sy, d_sz, d_tc, d_col} = dt_rd;
	assign xfull = (cnt_q == (XW+1)'(ExportVertices));
	assign ofull = (ofree_q >= (EW+1)'(TableEntries));
	assign dif = (cfg_n && (d_sx != snx || d_sy != sny || d_sz != snz))
		|| (cfg_t && d_tc != c_q.tc) || (cfg_c && d_col != c_q.col);
	assign busy_out = out_v_q && !pop;
	assign empty = !out_v_q;
	assign res = out_q;
	assign cq_take = (st_q == S_IDLE) && cq_valid && !busy_out;

	always_comb begin
		lk_we = 1'b0;
		lk_wa = e_q;
		lk_wd = {1'b1, {EW{1'b1}}};
		lk_ra = e_q;
		dt_we = 1'b0;
		dt_wa = e_q;
		dt_wd = {cnt_q[XW-1:0], snx, sny, snz, c_q.tc, c_q.col};
		dt_ra = e_q;
		xp_we = 1'b0;
		xp_wa = cnt_q[XW-1:0];
		xp_wd = {e_q, c_q.orig};
		xp_ra = c_q.ridx[XW-1:0];
		if (cq_take) begin
			lk_ra = cq_data.orig[EW-1:0];
			dt_ra = cq_data.orig[EW-1:0];
		end
		case (st_q)
			S_CLR: begin
				lk_we = 1'b1;
				lk_wa = clr_q;
				lk_wd = {1'b0, {EW{1'b1}}};
			end
			S_CMP: begin
				if (!lvalid) begin
					if (!xfull) begin
						lk_we = 1'b1;
						dt_we = 1'b1;
						xp_we = 1'b1;
					end
				end else if (!dif) begin
					if (!cfg_n) begin
						dt_we = 1'b1;
						dt_wd = {eidx, sat_add(d_sx, c_q.nx), sat_add(d_sy, c_q.ny),
							sat_add(d_sz, c_q.nz), d_tc, d_col};
					end
				end else if (!has_next) begin
					if (!xfull && !ofull) begin
						lk_we = 1'b1;
						lk_wd = {1'b1, ofree_q[EW-1:0]};
					end
				end
			end
			S_NXT: begin
				lk_we = 1'b1;
				lk_wa = ofree_q[EW-1:0] - 1'b1;
				dt_we = 1'b1;
				dt_wa = lk_wa;
				xp_we = 1'b1;
				xp_wd = {lk_wa, c_q.orig};
			end
			S_RD2: begin
				lk_ra = xp_rd[EW+11:12];
				dt_ra = xp_rd[EW+11:12];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cq_take) begin
			c_q <= cq_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		res_t r_n;
		logic v_n;
		if (!arst_n) begin
			st_q <= S_CLR;
			e_q <= '0;
			steps_q <= '0;
			cnt_q <= '0;
			ofree_q <= (EW+1)'(OrigVertices);
			clr_q <= '0;
			out_v_q <= 1'b0;
			out_q <= '0;
		end else begin
			r_n = out_q;
			v_n = out_v_q && !pop;
			case (st_q)
				S_IDLE: begin
					if (cq_take) begin
						e_q <= cq_data.orig[EW-1:0];
						steps_q <= '0;
						case (cq_data.func)
							FUNC_ADD: begin
								if (32'(cq_data.orig) >= OrigVertices
									|| 32'(cq_data.orig) >= TableEntries) begin
									r_n = '0;
									r_n.table_full = 1'b1;
									v_n = 1'b1;
								end else begin
									st_q <= S_WALK;
								end
							end
							FUNC_READ: st_q <= S_RD1;
							default: begin
								st_q <= S_CLR;
								clr_q <= '0;
								cnt_q <= '0;
								ofree_q <= (EW+1)'(OrigVertices);
								r_n = '0;
								v_n = 1'b1;
							end
						endcase
					end
				end
				S_WALK: st_q <= S_CMP;
				S_CMP: begin
					r_n = '0;
					if (!lvalid) begin
						v_n = 1'b1;
						st_q <= S_IDLE;
						if (xfull) begin
							r_n.table_full = 1'b1;
						end else begin
							r_n.export_vertex = 13'(cnt_q);
							r_n.is_new = 1'b1;
							cnt_q <= cnt_q + 1'b1;
						end
					end else if (!dif) begin
						v_n = 1'b1;
						st_q <= S_IDLE;
						r_n.export_vertex = 13'(eidx);
					end else if (!has_next || 32'(lnext) >= TableEntries) begin
						if (xfull || ofull) begin
							v_n = 1'b1;
							st_q <= S_IDLE;
							r_n.table_full = 1'b1;
						end else begin
							ofree_q <= ofree_q + 1'b1;
							st_q <= S_NXT;
						end
					end else if (32'(steps_q) >= TableEntries) begin
						v_n = 1'b1;
						st_q <= S_IDLE;
						r_n.table_full = 1'b1;
					end else begin
						e_q <= lnext;
						steps_q <= steps_q + 1'b1;
						st_q <= S_WALK;
					end
				end
				S_NXT: begin
					r_n = '0;
					r_n.export_vertex = 13'(cnt_q);
					r_n.is_new = 1'b1;
					cnt_q <= cnt_q + 1'b1;
					v_n = 1'b1;
					st_q <= S_IDLE;
				end
				S_RD1: st_q <= S_RD2;
				S_RD2: st_q <= S_RD3;
				S_RD3: begin
					r_n = '0;
					r_n.export_vertex = c_q.ridx;
					if ((XW+1)'(c_q.ridx) < cnt_q) begin
						r_n.orig = xp_rd[11:0];
						r_n.sx = d_sx;
						r_n.sy = d_sy;
						r_n.sz = d_sz;
						r_n.tu = d_tc[15:0];
						r_n.tv = d_tc[31:16];
						r_n.col = d_col;
					end
					v_n = 1'b1;
					st_q <= S_IDLE;
				end
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == {EW{1'b1}}) begin
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
			out_q <= r_n;
			out_v_q <= v_n;
		end
	end

	`VAS_ASSERT_IMPLY(a_take_idle, cq_take, st_q == S_IDLE && !busy_out, "take while busy")
	`VAS_ASSERT_IMPLY(a_cnt_max, 1'b1, cnt_q <= (XW+1)'(ExportVertices), "export count overrun")
	`VAS_ASSERT_NEXT(a_new_count, st_q == S_NXT, cnt_q == $past(cnt_q) + 1'b1,
		"overflow entry did not count")
endmodule

// File: hdl/vertex_attribute_splitter_core.sv
// Vertex attribute splitter. Face corners are welded into export vertices by walking a chain
// of table entries rooted at the corner's original vertex. Commands enter a two-deep queue and
// are executed one at a time by a sequencer over simple dual-port table memories: an add
// corner walks and compares each chain entry and may add an overflow link, a read steps
// through RD1, RD2 and RD3, and a clear, like reset, sweeps the link table, during which no
// transaction is started. A result that is not popped holds the sequencer until it is taken.
// The user must write registers only while the block is idle; the block does not enforce it.
module vertex_attribute_splitter_core import vas_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic cfg_data,
	input logic push,
	output logic full,
	input logic [1:0] func,
	input logic [11:0] orig_vertex,
	input logic signed [15:0] normal_x,
	input logic signed [15:0] normal_y,
	input logic signed [15:0] normal_z,
	input logic signed [15:0] tex_u,
	input logic signed [15:0] tex_v,
	input logic [31:0] corner_color,
	input logic [12:0] read_index,
	output logic empty,
	input logic pop,
	output logic [12:0] export_vertex,
	output logic is_new,
	output logic table_full,
	output logic [11:0] out_orig_vertex,
	output logic signed [31:0] sum_normal_x,
	output logic signed [31:0] sum_normal_y,
	output logic signed [31:0] sum_normal_z,
	output logic signed [15:0] out_tex_u,
	output logic signed [15:0] out_tex_v,
	output logic [31:0] out_color
);
	logic split_n_q, split_t_q, split_c_q;
	logic cq_valid, cq_take;
	cmd_t cq_data;
	res_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			split_n_q <= 1'b1;
			split_t_q <= 1'b1;
			split_c_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SPLIT_NORMAL: split_n_q <= cfg_data;
				REG_SPLIT_TEXCOORD: split_t_q <= cfg_data;
				REG_SPLIT_COLOR: split_c_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	vas_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .func(func),
		.orig_vertex(orig_vertex), .normal_x(normal_x), .normal_y(normal_y),
		.normal_z(normal_z), .tex_u(tex_u), .tex_v(tex_v), .corner_color(corner_color),
		.read_index(read_index), .cq_valid(cq_valid), .cq_data(cq_data), .cq_take(cq_take));

	vas_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg_n(split_n_q), .cfg_t(split_t_q), .cfg_c(split_c_q),
		.cq_valid(cq_valid), .cq_data(cq_data), .cq_take(cq_take), .empty(empty), .pop(pop),
		.res(res));

	assign export_vertex = res.export_vertex;
	assign is_new = res.is_new;
	assign table_full = res.table_full;
	assign out_orig_vertex = res.orig;
	assign sum_normal_x = res.sx;
	assign sum_normal_y = res.sy;
	assign sum_normal_z = res.sz;
	assign out_tex_u = res.tu;
	assign out_tex_v = res.tv;
	assign out_color = res.col;
endmodule

// File: sim/vas_checker.sv
`timescale 1ns / 100ps

module vas_checker import vas_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic cfg_data,
	input logic push,
	input logic full,
	input logic [1:0] func,
	input logic [11:0] orig_vertex,
	input logic signed [15:0] normal_x,
	input logic signed [15:0] normal_y,
	input logic signed [15:0] normal_z,
	input logic signed [15:0] tex_u,
	input logic signed [15:0] tex_v,
	input logic [31:0] corner_color,
	input logic [12:0] read_index,
	input logic empty,
	input logic pop,
	input logic [12:0] export_vertex,
	input logic is_new,
	input logic table_full,
	input logic [11:0] out_orig_vertex,
	input logic signed [31:0] sum_normal_x,
	input logic signed [31:0] sum_normal_y,
	input logic signed [31:0] sum_normal_z,
	input logic signed [15:0] out_tex_u,
	input logic signed [15:0] out_tex_v,
	input logic [31:0] out_color,
	output int errors,
	output int pending
);
	logic split_n, split_t, split_c;
	bit valid_tab[TableEntries];
	int next_tab[TableEntries];
	int xidx_tab[TableEntries];
	logic [31:0] nsum_tab[TableEntries][3];
	logic [31:0] tc_tab[TableEntries];
	logic [31:0] col_tab[TableEntries];
	int xentry[ExportVertices];
	logic [11:0] xorig[ExportVertices];
	int xcount;
	int ovf_free;
	res_t vertex_q[$];

	function automatic logic [31:0] sat_sum(input logic [31:0] s, input logic signed [15:0] a);
		longint r;
		r = longint'($signed(s)) + longint'(a);
		if (r > 64'sd2147483647) r = 64'sd2147483647;
		if (r < -64'sd2147483648) r = -64'sd2147483648;
		return r[31:0];
	endfunction

	task automatic wipe_tables();
		for (int i = 0; i < TableEntries; i++) begin
			valid_tab[i] = 0;
			next_tab[i] = -1;
		end
		xcount = 0;
		ovf_free = OrigVertices;
	endtask

	task automatic fill_entry(input int e);
		valid_tab[e] = 1;
		next_tab[e] = -1;
		xidx_tab[e] = xcount;
		nsum_tab[e][0] = 32'(normal_x);
		nsum_tab[e][1] = 32'(normal_y);
		nsum_tab[e][2] = 32'(normal_z);
		tc_tab[e] = {tex_v, tex_u};
		col_tab[e] = corner_color;
		xentry[xcount] = e;
		xorig[xcount] = orig_vertex;
		xcount++;
	endtask

	task automatic weld_corner(output res_t r);
		int e;
		bit dif;
		r = '0;
		e = orig_vertex;
		forever begin
			if (!valid_tab[e]) begin
				if (xcount >= ExportVertices) begin
					r.table_full = 1;
					return;
				end
				fill_entry(e);
				r.export_vertex = 13'(xcount - 1);
				r.is_new = 1;
				return;
			end
			dif = (split_n && (nsum_tab[e][0] != 32'(normal_x) ||
				nsum_tab[e][1] != 32'(normal_y) || nsum_tab[e][2] != 32'(normal_z))) ||
				(split_t && tc_tab[e] != {tex_v, tex_u}) ||
				(split_c && col_tab[e] != corner_color);
			if (!dif) begin
				if (!split_n) begin
					nsum_tab[e][0] = sat_sum(nsum_tab[e][0], normal_x);
					nsum_tab[e][1] = sat_sum(nsum_tab[e][1], normal_y);
					nsum_tab[e][2] = sat_sum(nsum_tab[e][2], normal_z);
				end
				r.export_vertex = 13'(xidx_tab[e]);
				return;
			end
			if (next_tab[e] < 0) begin
				if (xcount >= ExportVertices || ovf_free >= TableEntries) begin
					r.table_full = 1;
					return;
				end
				next_tab[e] = ovf_free;
				ovf_free++;
				fill_entry(next_tab[e]);
				r.export_vertex = 13'(xcount - 1);
				r.is_new = 1;
				return;
			end
			e = next_tab[e];
		end
	endtask

	function automatic res_t read_vertex();
		res_t r;
		int e;
		r = '0;
		r.export_vertex = read_index;
		if (read_index < xcount) begin
			e = xentry[read_index];
			r.orig = xorig[read_index];
			r.sx = nsum_tab[e][0];
			r.sy = nsum_tab[e][1];
			r.sz = nsum_tab[e][2];
			r.tu = tc_tab[e][15:0];
			r.tv = tc_tab[e][31:16];
			r.col = col_tab[e];
		end
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] seen, inout bit bad);
		if (seen !== want) begin
			if (errors < 10)
				$display("%0t: %s mismatch, expected %h, got %h", $realtime, name, want, seen);
			bad = 1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t r;
		res_t got;
		bit bad;
		if (!arst_n) begin
			split_n <= 1;
			split_t <= 1;
			split_c <= 0;
			wipe_tables();
			vertex_q.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_SPLIT_NORMAL: split_n <= cfg_data;
					REG_SPLIT_TEXCOORD: split_t <= cfg_data;
					REG_SPLIT_COLOR: split_c <= cfg_data;
					default: ;
				endcase
			end
			if (push && !full) begin
				case (func)
					FUNC_ADD: begin
						weld_corner(r);
						vertex_q.insert(vertex_q.size(), r);
					end
					FUNC_READ: vertex_q.insert(vertex_q.size(), read_vertex());
					FUNC_CLEAR: begin
						wipe_tables();
						vertex_q.insert(vertex_q.size(), '0);
					end
					default: ;
				endcase
			end
			if (pop && !empty) begin
				got = {export_vertex, is_new, table_full, out_orig_vertex, sum_normal_x,
					sum_normal_y, sum_normal_z, out_tex_u, out_tex_v, out_color};
				if (vertex_q.size() == 0) begin
					if (errors < 10) $display("%0t: result with no transaction waiting", $realtime);
					errors++;
				end else begin
					r = vertex_q.pop_front();
					bad = 0;
					check_field("export_vertex", 32'(r.export_vertex), 32'(got.export_vertex), bad);
					check_field("is_new", 32'(r.is_new), 32'(got.is_new), bad);
					check_field("table_full", 32'(r.table_full), 32'(got.table_full), bad);
					check_field("out_orig_vertex", 32'(r.orig), 32'(got.orig), bad);
					check_field("sum_normal_x", r.sx, got.sx, bad);
					check_field("sum_normal_y", r.sy, got.sy, bad);
					check_field("sum_normal_z", r.sz, got.sz, bad);
					check_field("out_tex_u", 32'(r.tu), 32'(got.tu), bad);
					check_field("out_tex_v", 32'(r.tv), 32'(got.tv), bad);
					check_field("out_color", r.col, got.col, bad);
					if (bad) errors++;
				end
			end
			pending = vertex_q.size();
		end
	end
endmodule

// File: sim/tb_vertex_attribute_splitter_core.sv
`timescale 1ns / 100ps

module tb_vertex_attribute_splitter_core import vas_pkg::*;;
	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [1:0] cfg_index = '0;
	logic cfg_data = 0;
	logic push = 0;
	logic full;
	logic [1:0] func = FUNC_NONE;
	logic [11:0] orig_vertex = '0;
	logic signed [15:0] normal_x = '0;
	logic signed [15:0] normal_y = '0;
	logic signed [15:0] normal_z = '0;
	logic signed [15:0] tex_u = '0;
	logic signed [15:0] tex_v = '0;
	logic [31:0] corner_color = '0;
	logic [12:0] read_index = '0;
	logic empty;
	logic pop = 0;
	logic [12:0] export_vertex;
	logic is_new;
	logic table_full;
	logic [11:0] out_orig_vertex;
	logic signed [31:0] sum_normal_x;
	logic signed [31:0] sum_normal_y;
	logic signed [31:0] sum_normal_z;
	logic signed [15:0] out_tex_u;
	logic signed [15:0] out_tex_v;
	logic [31:0] out_color;
	int errors;
	int pending;
	bit idle_on = 1;
	bit clear_sent = 1;

	vertex_attribute_splitter_core DUT (.*);
	vas_checker u_checker (.*);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	initial begin
		#60ms;
		$display("Verification failed");
		$finish;
	end

	always @(posedge clk) begin
		int stall;
		if (stall > 0) begin
			pop <= 0;
			stall--;
		end else begin
			pop <= 1;
			if (idle_on && $urandom_range(0, 7) == 0) stall = $urandom_range(1, 9);
		end
	end

	task automatic put(input logic [1:0] f, input logic [11:0] o, input logic [15:0] nx,
			input logic [15:0] ny, input logic [15:0] nz, input logic [15:0] u,
			input logic [15:0] v, input logic [31:0] c, input logic [12:0] ri);
		if (idle_on && $urandom_range(0, 7) == 0) begin
			push <= 0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		func <= f;
		orig_vertex <= o;
		normal_x <= nx;
		normal_y <= ny;
		normal_z <= nz;
		tex_u <= u;
		tex_v <= v;
		corner_color <= c;
		read_index <= ri;
		push <= 1;
		@(posedge clk);
		while (full) @(posedge clk);
		if (f == FUNC_CLEAR) clear_sent = 1;
	endtask

	task automatic settle();
		push <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (clear_sent ? 16500 : 30) @(posedge clk);
		clear_sent = 0;
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_we <= 1;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic set_splits(input logic n, input logic t, input logic c);
		settle();
		write_reg(REG_SPLIT_NORMAL, n);
		write_reg(REG_SPLIT_TEXCOORD, t);
		write_reg(REG_SPLIT_COLOR, c);
	endtask

	function automatic logic [15:0] pick16();
		case ($urandom_range(0, 5))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'h0000;
			3: return 16'h1000;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic random_items(input int n);
		int r;
		logic [1:0] f;
		logic [31:0] c;
		for (int i = 0; i < n; i++) begin
			if (i == n / 2 && $urandom_range(0, 1) == 0) begin
				push <= 0;
				@(posedge clk);
				while (pending != 0) @(posedge clk);
			end
			r = $urandom_range(0, 99);
			f = r < 62 ? FUNC_ADD : r < 92 ? FUNC_READ : r < 95 ? FUNC_NONE :
				r < 96 ? FUNC_CLEAR : FUNC_ADD;
			c = $urandom_range(0, 3) == 0 ? $urandom : 32'(32'hff00_0000 + $urandom_range(0, 2));
			put(f, $urandom_range(0, 4) == 0 ? 12'($urandom) : 12'($urandom_range(0, 11)),
				pick16(), pick16(), pick16(), pick16(), pick16(), c,
				$urandom_range(0, 3) == 0 ? 13'($urandom) : 13'($urandom_range(0, 47)));
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1;

		// Extremes, matching, overflow links, reads, unused code and clear.
		set_splits(1, 1, 0);
		put(FUNC_ADD, 12'd0, 16'h7fff, 16'h8000, 16'h0000, 16'h7fff, 16'h8000, 32'h0, 13'd0);
		put(FUNC_ADD, 12'd0, 16'h7fff, 16'h8000, 16'h0000, 16'h7fff, 16'h8000, 32'hffffffff, 13'd0);
		put(FUNC_ADD, 12'd0, 16'h8000, 16'h7fff, 16'hffff, 16'h7fff, 16'h8000, 32'h0, 13'd0);
		put(FUNC_ADD, 12'd0, 16'h8000, 16'h7fff, 16'hffff, 16'h8000, 16'h7fff, 32'h0, 13'd0);
		put(FUNC_ADD, 12'd4095, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
			32'hffffffff, 13'd0);
		put(FUNC_ADD, 12'd4095, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 32'h5a5a, 13'd0);
		put(FUNC_READ, 12'd0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 32'h0, 13'd0);
		put(FUNC_READ, 12'd0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 32'h0, 13'd3);
		put(FUNC_READ, 12'hfff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
			32'hffffffff, 13'd8191);
		put(FUNC_NONE, 12'd1, 16'h1, 16'h1, 16'h1, 16'h1, 16'h1, 32'h1, 13'd1);
		put(FUNC_READ, 12'd0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 32'h0, 13'd4);
		set_splits(0, 0, 1);
		put(FUNC_ADD, 12'd0, 16'h1234, 16'h1, 16'h2, 16'h3, 16'h4, 32'h0, 13'd0);
		put(FUNC_ADD, 12'd0, 16'h1234, 16'h1, 16'h2, 16'h3, 16'h4, 32'h77, 13'd0);
		put(FUNC_READ, 12'd0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 32'h0, 13'd0);
		put(FUNC_CLEAR, 12'hfff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
			32'hffffffff, 13'h1fff);
		put(FUNC_READ, 12'd0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 32'h0, 13'd0);

		random_items(210);
		set_splits(0, 0, 0);
		random_items(210);
		set_splits(1, 1, 1);
		random_items(210);
		set_splits(0, 1, 1);
		random_items(210);
		set_splits(1, 0, 0);
		idle_on = 0;
		random_items(210);

		settle();
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule

// File: vertex_attribute_splitter_core.f
+incdir+hdl
hdl/vas_pkg.sv
hdl/vas_ram.sv
hdl/vas_front.sv
hdl/vas_back.sv
hdl/vertex_attribute_splitter_core.sv
sim/vas_checker.sv
sim/tb_vertex_attribute_splitter_core.sv
